// ===== sv/pecp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pecp_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 14;
  localparam int AVG_SHIFT = 4;
  localparam int ERR_W    = 8;
  localparam int CALC_W   = 12;
  localparam int COUNT_W  = 16;
  localparam int STILL_W  = 4;
  localparam int WIN_W    = 6;
  localparam int RATE_W   = 14;
  localparam int SLOT_OUT_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_CAP    = 16'hFF00;
  localparam logic [STILL_W-1:0] VALID_CAP    = 4'hF;
  localparam logic [WIN_W-1:0]   WINDOW_TICKS = 6'd40;

  localparam logic signed [CALC_W-1:0] ERR_MAX = 12'sd127;
  localparam logic signed [CALC_W-1:0] ERR_MIN = -12'sd128;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_ERROR_OFFSET = 1'b0,
    REG_MIN_READING  = 1'b1
  } reg_index_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_t;

endpackage

`default_nettype wire

// ===== sv/pulse_error_capture_prf_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// pulse error capture and pulse-rate meter
// input channel (in_valid/in_ready) carries one beat per converter pair or
// per 100 ms tick; kind selects which. every accepted beat gives exactly one
// result beat on the output channel (out_valid/out_ready).
// a pulse closes on its final sample pair: the sums are averaged, the error
// is formed and clamped, and the ring slot, still count and pulse count move.
// every 40 ticks the pulse rate is reloaded from the window count.
// each result shows in the cycle after its input beat; one beat per cycle
// while out_ready is high, set by the single result register.
// in_ready stays high while the result register is empty or being taken, so
// a new beat enters in the same cycle as the previous result leaves.
// if the receiver stalls, the result holds and in_ready drops until it goes.
// synchronous reset clears all counters, sums, the ring pointer, the pulse
// rate and both configuration registers, and empties the result register.
// configuration is written over the apb port: error_offset at 0x0,
// min_reading at 0x4; write them only while no beat is in flight.
module pulse_error_capture_prf_meter
  import pecp_pkg::*;
#(
  parameter int SAMPLES_PER_PULSE = 15,
  parameter int HISTORY_DEPTH     = 16,
  parameter int ADC_BITS          = 10
) (
  input  wire                         clk,
  input  wire                         rst,
  // apb configuration
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [APB_ADDR_W-1:0]       paddr,
  input  wire  [APB_DATA_W-1:0]       pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready,
  // input channel
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         kind,
  input  wire  [SAMPLE_W-1:0]         sigma_sample,
  input  wire  [SAMPLE_W-1:0]         delta_sample,
  input  wire                         motor_moving,
  input  wire                         skip_pulse,
  // output channel
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        pulse_done,
  output logic signed [ERR_W-1:0]     error_value,
  output logic [SLOT_OUT_W-1:0]       history_slot,
  output logic [STILL_W-1:0]          valid_count,
  output logic [COUNT_W-1:0]          pulse_count,
  output logic [COUNT_W-1:0]          time_off,
  output logic                        rate_updated,
  output logic [RATE_W-1:0]           pulse_rate
);

  localparam int IDX_W  = $clog2(SAMPLES_PER_PULSE) + 1;
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_INDEX = IDX_W'(SAMPLES_PER_PULSE - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

  // configuration
  logic signed [ERR_W-1:0]  error_offset;
  logic [SAMPLE_W-1:0]      min_reading;
  logic                     cfg_write;
  reg_index_t               cfg_index;

  // state
  logic [IDX_W-1:0]   sample_index, sample_index_next;
  logic [SUM_W-1:0]   sigma_sum, sigma_sum_next;
  logic [SUM_W-1:0]   delta_sum, delta_sum_next;
  logic [SLOT_W-1:0]  write_slot, write_slot_next;
  logic [STILL_W-1:0] still_count, still_count_next;
  logic [COUNT_W-1:0] pulse_total, pulse_total_next;
  logic [COUNT_W-1:0] idle_ticks, idle_ticks_next;
  logic [COUNT_W-1:0] window_pulses, window_pulses_next;
  logic [WIN_W-1:0]   window_ticks, window_ticks_next;
  logic [RATE_W-1:0]  rate_value, rate_value_next;

  // per-beat working values
  logic                      in_beat;
  logic                      take_sample;
  logic                      close_pulse;
  logic                      close_window;
  logic [SUM_W-1:0]          sigma_acc, delta_acc;
  logic [SAMPLE_W-1:0]       sigma_avg, delta_avg;
  logic signed [CALC_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]   err_clamped;
  logic signed [ERR_W-1:0]   err_final;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[2]);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_offset <= '0;
      min_reading  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ERROR_OFFSET: error_offset <= pwdata[ERR_W-1:0];
        REG_MIN_READING:  min_reading  <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_ERROR_OFFSET: prdata = {{(APB_DATA_W-ERR_W){1'b0}}, error_offset};
      REG_MIN_READING:  prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, min_reading};
      default:          prdata = '0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  assign take_sample  = (kind == KIND_SAMPLE) && !skip_pulse;
  assign close_pulse  = take_sample && (sample_index == LAST_INDEX);
  assign close_window = (kind == KIND_TICK) && (window_ticks == WINDOW_TICKS - 1'b1);

  assign sigma_acc = sigma_sum + SUM_W'(sigma_sample & ADC_MASK);
  assign delta_acc = delta_sum + SUM_W'(delta_sample & ADC_MASK);
  assign sigma_avg = sigma_acc[AVG_SHIFT +: SAMPLE_W];
  assign delta_avg = delta_acc[AVG_SHIFT +: SAMPLE_W];

  assign err_raw = $signed({2'b00, sigma_avg}) - $signed({2'b00, delta_avg})
                 + CALC_W'(error_offset);

  always_comb begin
    if (err_raw > ERR_MAX) begin
      err_clamped = ERR_MAX[ERR_W-1:0];
    end else if (err_raw < ERR_MIN) begin
      err_clamped = ERR_MIN[ERR_W-1:0];
    end else begin
      err_clamped = err_raw[ERR_W-1:0];
    end
    // weak return on either channel means no usable pulse
    if (sigma_avg <= min_reading || delta_avg <= min_reading) begin
      err_final = '0;
    end else begin
      err_final = err_clamped;
    end
  end

  assign slot_wide = {{SLOT_OUT_W{1'b0}}, write_slot};

  always_comb begin
    sample_index_next  = sample_index;
    sigma_sum_next     = sigma_sum;
    delta_sum_next     = delta_sum;
    write_slot_next    = write_slot;
    still_count_next   = still_count;
    pulse_total_next   = pulse_total;
    idle_ticks_next    = idle_ticks;
    window_pulses_next = window_pulses;
    window_ticks_next  = window_ticks;
    rate_value_next    = rate_value;

    if (kind == KIND_SAMPLE) begin
      if (close_pulse) begin
        sample_index_next = '0;
        sigma_sum_next    = '0;
        delta_sum_next    = '0;
        write_slot_next   = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
        if (motor_moving) begin
          still_count_next = STILL_W'(1);
        end else if (still_count == VALID_CAP) begin
          still_count_next = VALID_CAP;
        end else begin
          still_count_next = still_count + 1'b1;
        end
        pulse_total_next   = (pulse_total == COUNT_CAP) ? COUNT_CAP : pulse_total + 1'b1;
        idle_ticks_next    = '0;
        window_pulses_next = window_pulses + 1'b1;
      end else if (take_sample) begin
        sample_index_next = sample_index + 1'b1;
        sigma_sum_next    = sigma_acc;
        delta_sum_next    = delta_acc;
      end
    end else begin
      if (close_window) begin
        window_ticks_next  = '0;
        rate_value_next    = window_pulses[2 +: RATE_W];
        window_pulses_next = '0;
      end else begin
        window_ticks_next = window_ticks + 1'b1;
      end
      idle_ticks_next = (idle_ticks == COUNT_CAP) ? COUNT_CAP : idle_ticks + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      sigma_sum     <= '0;
      delta_sum     <= '0;
      write_slot    <= '0;
      still_count   <= '0;
      pulse_total   <= '0;
      idle_ticks    <= '0;
      window_pulses <= '0;
      window_ticks  <= '0;
      rate_value    <= '0;
    end else if (in_beat) begin
      sample_index  <= sample_index_next;
      sigma_sum     <= sigma_sum_next;
      delta_sum     <= delta_sum_next;
      write_slot    <= write_slot_next;
      still_count   <= still_count_next;
      pulse_total   <= pulse_total_next;
      idle_ticks    <= idle_ticks_next;
      window_pulses <= window_pulses_next;
      window_ticks  <= window_ticks_next;
      rate_value    <= rate_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      pulse_done   <= close_pulse;
      error_value  <= close_pulse ? err_final : '0;
      history_slot <= close_pulse ? slot_wide[SLOT_OUT_W-1:0] : '0;
      valid_count  <= still_count_next;
      pulse_count  <= pulse_total_next;
      time_off     <= idle_ticks_next;
      rate_updated <= close_window;
      pulse_rate   <= rate_value_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pecp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pecp_checker
  import pecp_pkg::*;
(
  input wire                      clk,
  input wire                      rst,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire                      pulse_done,
  input wire signed [ERR_W-1:0]   error_value,
  input wire [SLOT_OUT_W-1:0]     history_slot,
  input wire [COUNT_W-1:0]        pulse_count,
  input wire [COUNT_W-1:0]        time_off,
  input wire                      rate_updated
);

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result register");

  // a beat is either a sample or a tick, never both events
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pulse_done && rate_updated))
    else $error("pulse and window closed on the same beat");

  // a pulse clears off-time and the pulse count is never zero after one
  a_pulse_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && pulse_done |-> time_off == '0 && pulse_count != '0)
    else $error("pulse counts inconsistent");

  a_no_pulse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pulse_done |-> error_value == '0 && history_slot == '0)
    else $error("error or slot set without a pulse");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_count) && $stable(time_off))
    else $error("result changed while stalled");

endmodule

bind pulse_error_capture_prf_meter pecp_checker u_pecp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pulse_done   (pulse_done),
  .error_value  (error_value),
  .history_slot (history_slot),
  .pulse_count  (pulse_count),
  .time_off     (time_off),
  .rate_updated (rate_updated)
);

`default_nettype wire

// ===== tb/pulse_error_capture_prf_meter_tb.sv =====
`timescale 1ns / 1ps

module pulse_error_capture_prf_meter_tb;
  import pecp_pkg::*;

  localparam int PULSE_SAMPLES = 15;
  localparam int SAMPLE_MAX    = 1023;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    item_kind_t          kind;
    logic [SAMPLE_W-1:0] sigma;
    logic [SAMPLE_W-1:0] delta;
    logic                moving;
    logic                skip;
  } sensor_item_t;

  typedef struct packed {
    logic                    done;
    logic signed [ERR_W-1:0] err;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [STILL_W-1:0]      still;
    logic [COUNT_W-1:0]      pulses;
    logic [COUNT_W-1:0]      idle;
    logic                    rate_upd;
    logic [RATE_W-1:0]       rate;
  } meter_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    kind = 1'b0;
  logic [SAMPLE_W-1:0]     sigma_sample = '0;
  logic [SAMPLE_W-1:0]     delta_sample = '0;
  logic                    motor_moving = 1'b0;
  logic                    skip_pulse = 1'b0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    pulse_done;
  logic signed [ERR_W-1:0] error_value;
  logic [SLOT_OUT_W-1:0]   history_slot;
  logic [STILL_W-1:0]      valid_count;
  logic [COUNT_W-1:0]      pulse_count;
  logic [COUNT_W-1:0]      time_off;
  logic                    rate_updated;
  logic [RATE_W-1:0]       pulse_rate;

  pulse_error_capture_prf_meter dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .sigma_sample (sigma_sample),
    .delta_sample (delta_sample),
    .motor_moving (motor_moving),
    .skip_pulse   (skip_pulse),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pulse_done   (pulse_done),
    .error_value  (error_value),
    .history_slot (history_slot),
    .valid_count  (valid_count),
    .pulse_count  (pulse_count),
    .time_off     (time_off),
    .rate_updated (rate_updated),
    .pulse_rate   (pulse_rate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [ERR_W-1:0]  cfg_offset = '0;
  logic [SAMPLE_W-1:0]      cfg_min = '0;
  logic [3:0]               samples_in = '0;
  logic [SUM_W-1:0]         sigma_acc = '0;
  logic [SUM_W-1:0]         delta_acc = '0;
  logic [SLOT_OUT_W-1:0]    ring_slot = '0;
  logic [STILL_W-1:0]       still_count = '0;
  logic [COUNT_W-1:0]       pulse_total = '0;
  logic [COUNT_W-1:0]       idle_ticks = '0;
  logic [COUNT_W-1:0]       window_pulses = '0;
  logic [WIN_W-1:0]         window_ticks = '0;
  logic [RATE_W-1:0]        rate_value = '0;

  sensor_item_t   sensor_items[$];
  meter_reading_t expected_readings[$];
  sensor_item_t   cur_item;
  meter_reading_t seen, want;

  int  mismatches = 0;
  int  cycles = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  pattern_pos = 0;
  logic [31:0] ready_pattern = '1;

  function automatic meter_reading_t meter_step(sensor_item_t it);
    meter_reading_t r;
    int s_avg, d_avg, e;
    r = '0;
    if (it.kind == KIND_SAMPLE) begin
      if (!it.skip) begin
        sigma_acc = sigma_acc + it.sigma;
        delta_acc = delta_acc + it.delta;
        samples_in = samples_in + 1'b1;
        if (samples_in >= PULSE_SAMPLES) begin
          s_avg = int'(sigma_acc >> AVG_SHIFT);
          d_avg = int'(delta_acc >> AVG_SHIFT);
          e = s_avg - d_avg + int'(cfg_offset);
          if (e > 127) e = 127;
          else if (e < -128) e = -128;
          if (s_avg <= int'(cfg_min) || d_avg <= int'(cfg_min)) e = 0;
          if (it.moving) still_count = '0;
          if (still_count != VALID_CAP) still_count = still_count + 1'b1;
          if (pulse_total != COUNT_CAP) pulse_total = pulse_total + 1'b1;
          idle_ticks = '0;
          window_pulses = window_pulses + 1'b1;
          samples_in = '0;
          sigma_acc = '0;
          delta_acc = '0;
          r.done = 1'b1;
          r.err = ERR_W'(e);
          r.slot = ring_slot;
          ring_slot = ring_slot + 1'b1;
        end
      end
    end else begin
      window_ticks = window_ticks + 1'b1;
      if (window_ticks >= WINDOW_TICKS) begin
        window_ticks = '0;
        rate_value = RATE_W'(window_pulses >> 2);
        window_pulses = '0;
        r.rate_upd = 1'b1;
      end
      if (idle_ticks != COUNT_CAP) idle_ticks = idle_ticks + 1'b1;
    end
    r.still = still_count;
    r.pulses = pulse_total;
    r.idle = idle_ticks;
    r.rate = rate_value;
    return r;
  endfunction

  function automatic sensor_item_t make_item(item_kind_t k, int s, int d, bit mv, bit sk);
    sensor_item_t it;
    it.kind = k;
    it.sigma = s[SAMPLE_W-1:0];
    it.delta = d[SAMPLE_W-1:0];
    it.moving = mv;
    it.skip = sk;
    return it;
  endfunction

  function automatic int lim(int v);
    return (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_v));
  endtask

  // sender: bursts of random length with gaps between
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(meter_step(cur_item));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sensor_items.size() != 0) begin
          cur_item = sensor_items.pop_front();
          kind <= cur_item.kind;
          sigma_sample <= cur_item.sigma;
          delta_sample <= cur_item.delta;
          motor_moving <= cur_item.moving;
          skip_pulse <= cur_item.skip;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result beat and stalls on its own pattern
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      seen = '{pulse_done, error_value, history_slot, valid_count, pulse_count, time_off,
               rate_updated, pulse_rate};
      if (expected_readings.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_readings.pop_front();
        check_field("pulse_done", seen.done, want.done);
        check_field("error_value", seen.err, want.err);
        check_field("history_slot", seen.slot, want.slot);
        check_field("valid_count", seen.still, want.still);
        check_field("pulse_count", seen.pulses, want.pulses);
        check_field("time_off", seen.idle, want.idle);
        check_field("rate_updated", seen.rate_upd, want.rate_upd);
        check_field("pulse_rate", seen.rate, want.rate);
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 250) begin
      // long hold-off so the block backs up and drops in_ready
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (pattern_pos == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = '1;
          1: ready_pattern = $urandom;
          2: ready_pattern = $urandom | $urandom;
          default: ready_pattern = $urandom & $urandom;
        endcase
      end
      out_ready <= ready_pattern[pattern_pos];
      pattern_pos = (pattern_pos + 1) % 32;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pulse_error_capture_prf_meter_tb: errors");
      $finish;
    end
  end

  task automatic cfg_write(reg_index_t idx, logic [APB_DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ERROR_OFFSET) cfg_offset = val[ERR_W-1:0];
    else cfg_min = val[SAMPLE_W-1:0];
  endtask

  task automatic set_config(int off, int minr);
    cfg_write(REG_ERROR_OFFSET, 32'(off));
    cfg_write(REG_MIN_READING, 32'(minr));
  endtask

  task automatic settle();
    while (sensor_items.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_tick();
    sensor_items.push_back(make_item(KIND_TICK, $urandom, $urandom, $urandom_range(0, 1),
                                     $urandom_range(0, 1)));
  endtask

  // one full pulse with random content, odd skipped beats and ticks woven in
  task automatic push_pulse(int mode, int move_odds);
    int base, s, d, t;
    bit mv;
    base = $urandom_range(0, SAMPLE_MAX);
    for (int i = 0; i < PULSE_SAMPLES; i++) begin
      if ($urandom_range(0, 11) == 0)
        sensor_items.push_back(make_item(KIND_SAMPLE, $urandom, $urandom,
                                         $urandom_range(0, 1), 1'b1));
      if ($urandom_range(0, 19) == 0) push_tick();
      case (mode)
        0: begin
          s = $urandom_range(0, SAMPLE_MAX);
          d = $urandom_range(0, SAMPLE_MAX);
        end
        1: begin
          s = $urandom_range(800, SAMPLE_MAX);
          d = $urandom_range(0, 200);
        end
        2: begin
          s = $urandom_range(0, 200);
          d = $urandom_range(800, SAMPLE_MAX);
        end
        3: begin
          d = base;
          s = lim(base + $urandom_range(0, 16) - 8);
        end
        4: begin
          // averages land close to the minimum reading
          t = int'(cfg_min) * 16 / 15 + $urandom_range(0, 6) - 3;
          s = lim(t);
          d = $urandom_range(0, 1) ? lim(t + $urandom_range(0, 4) - 2)
                                   : $urandom_range(0, SAMPLE_MAX);
        end
        default: begin
          s = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
          d = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        end
      endcase
      mv = (move_odds != 0) && ($urandom_range(1, move_odds) == 1);
      sensor_items.push_back(make_item(KIND_SAMPLE, s, d, mv, 1'b0));
    end
  endtask

  task automatic run_random(int n_items, int move_odds, int mode_lo, int mode_hi);
    int count, r, n;
    count = 0;
    while (count < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        push_pulse($urandom_range(mode_lo, mode_hi), move_odds);
        count += PULSE_SAMPLES;
      end else if (r < 9) begin
        n = $urandom_range(1, 8);
        repeat (n) push_tick();
        count += n;
      end else begin
        sensor_items.push_back(make_item(item_kind_t'($urandom_range(0, 1)), $urandom, $urandom,
                                         $urandom_range(0, 1), $urandom_range(0, 3) == 0));
        count++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: ignored tick fields, skipped sample mid pulse, high clamp
    sensor_items.push_back(make_item(KIND_TICK, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1));
    repeat (7) sensor_items.push_back(make_item(KIND_SAMPLE, SAMPLE_MAX, 2, 1'b1, 1'b0));
    sensor_items.push_back(make_item(KIND_SAMPLE, 0, 0, 1'b1, 1'b1));
    sensor_items.push_back(make_item(KIND_TICK, 0, 0, 1'b0, 1'b0));
    repeat (7) sensor_items.push_back(make_item(KIND_SAMPLE, SAMPLE_MAX, 2, 1'b1, 1'b0));
    sensor_items.push_back(make_item(KIND_SAMPLE, SAMPLE_MAX, 2, 1'b0, 1'b0));
    run_random(150, 8, 0, 5);
    settle();

    set_config(127, 0);
    run_random(150, 4, 0, 5);
    settle();

    set_config(-128, 1023);
    run_random(60, 8, 0, 5);
    settle();

    set_config(-128, 0);
    run_random(100, 0, 0, 5);
    settle();

    set_config($urandom_range(0, 255) - 128, $urandom_range(0, 60));
    run_random(150, 2, 0, 5);
    settle();

    set_config($urandom_range(0, 255) - 128, $urandom_range(0, 1023));
    run_random(120, 8, 3, 4);
    settle();

    // back to defaults for a final mixed stretch
    set_config(0, 0);
    run_random(80, 8, 0, 5);
    settle();

    repeat (8) @(posedge clk);
    if (expected_readings.size() != 0) report_mismatch("results still outstanding at end");
    if (mismatches == 0) begin
      $display("pulse_error_capture_prf_meter_tb: clean");
    end else begin
      $display("pulse_error_capture_prf_meter_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pecp_pkg.sv
sv/pulse_error_capture_prf_meter.sv
sv/pecp_checker.sv
tb/pulse_error_capture_prf_meter_tb.sv
